// ===== design/lgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the life generation step
// Payload structs, register indexes, sequencer states and the neighbor
// flags passed from the sequencer to the row unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int ROW_IDX_BITS  = 6;
   localparam int CELL_BITS     = 64;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WRAP_MODE    = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] ROW_COUNT_RESET    = 7'd64;
   localparam logic [CSR_DATA_BITS-1:0] COLUMN_COUNT_RESET = 7'd64;

   // Birth and survival neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic                    operation;
      logic [ROW_IDX_BITS-1:0] row_index;
      logic [CELL_BITS-1:0]    row_cells;
   } req_type;

   typedef struct packed {
      logic [ROW_IDX_BITS-1:0] out_row_index;
      logic [CELL_BITS-1:0]    out_row_cells;
      logic                    last_row;
   } rsp_type;

   // Window qualifiers for the row being computed
   typedef struct packed {
      logic up_valid;    // row above exists (or wraps)
      logic down_valid;  // row below exists (or wraps)
      logic row_self;    // row above/below is the row itself (one-row torus)
      logic col_self;    // left/right column is the cell itself (one-column torus)
   } flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_UP,
      ST_FILL_MID,
      ST_RUN,
      ST_LAST
   } state_type;

endpackage

// ===== design/lgs_cell_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell_lane: next state of one cell
// Counts the live neighbors in a 3x3 window and applies the birth and
// survival rule. Bit 0 of each row slice is left, bit 1 center, bit 2 right.
// ----------------------------------------------------------------------------
module lgs_cell_lane
   import lgs_pkg::*;
(
   input  logic [2:0] up_bits,
   input  logic [2:0] mid_bits,
   input  logic [2:0] down_bits,
   input  flags_type  flags,
   output logic       alive
);

   logic [7:0] terms;
   logic [3:0] count;

   always_comb begin
      // on a one-row or one-column torus some offsets land on the cell itself
      terms[0] = up_bits[0]   & flags.up_valid   & ~(flags.row_self & flags.col_self);
      terms[1] = up_bits[1]   & flags.up_valid   & ~flags.row_self;
      terms[2] = up_bits[2]   & flags.up_valid   & ~(flags.row_self & flags.col_self);
      terms[3] = mid_bits[0]  & ~flags.col_self;
      terms[4] = mid_bits[2]  & ~flags.col_self;
      terms[5] = down_bits[0] & flags.down_valid & ~(flags.row_self & flags.col_self);
      terms[6] = down_bits[1] & flags.down_valid & ~flags.row_self;
      terms[7] = down_bits[2] & flags.down_valid & ~(flags.row_self & flags.col_self);
   end

   always_comb begin
      count = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + 4'(terms[k]);
      end
   end

   assign alive = (count == BIRTH_COUNT) | ((count == SURVIVE_COUNT) & mid_bits[1]);

endmodule

// ===== design/lgs_row_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_row_unit: one new row from a three-row window
// Builds left/right neighbor vectors with optional edge wrap, runs one
// cell lane per column and merges the lane results into a masked row word.
// ----------------------------------------------------------------------------
module lgs_row_unit
   import lgs_pkg::*;
#(
   parameter int COLS = 64
) (
   input  logic [COLS-1:0]              up_word,
   input  logic [COLS-1:0]              mid_word,
   input  logic [COLS-1:0]              down_word,
   input  logic [$clog2(COLS+1)-1:0]    cols_used,
   input  logic                         wrap,
   input  flags_type                    flags,
   output logic [COLS-1:0]              next_word
);

   localparam int COL_IDX_W = $clog2(COLS);
   localparam int COL_CNT_W = $clog2(COLS+1);

   logic [COLS-1:0]      col_mask;
   logic [COL_IDX_W-1:0] last_col;
   logic [COLS-1:0]      win   [3];
   logic [COLS-1:0]      win_m [3];
   logic [COLS-1:0]      left  [3];
   logic [COLS-1:0]      right [3];
   logic [COLS-1:0]      lane_alive;

   assign last_col = COL_IDX_W'(cols_used - COL_CNT_W'(1));

   always_comb begin
      for (int j = 0; j < COLS; j++) begin
         col_mask[j] = (COL_CNT_W'(j) < cols_used);
      end
   end

   assign win[0] = up_word;
   assign win[1] = mid_word;
   assign win[2] = down_word;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_m[r] = win[r] & col_mask;
         // bits past the last used column are already zero in win_m
         left[r]  = win_m[r] << 1;
         right[r] = win_m[r] >> 1;
         if (wrap) begin
            left[r][0]         = win_m[r][last_col];
            right[r][last_col] = right[r][last_col] | win_m[r][0];
         end
      end
   end

   for (genvar j = 0; j < COLS; j++) begin : g_lane
      lgs_cell_lane u_lane (
         .up_bits   ({right[0][j], win_m[0][j], left[0][j]}),
         .mid_bits  ({right[1][j], win_m[1][j], left[1][j]}),
         .down_bits ({right[2][j], win_m[2][j], left[2][j]}),
         .flags     (flags),
         .alive     (lane_alive[j])
      );
   end

   assign next_word = lane_alive & col_mask;

endmodule

// ===== design/life_generation_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_step: one Game of Life generation over a stored board
// Loads board rows, and on a tick streams the next generation row by row
// while writing it back over the board.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   start, busy, req_payload            accept on start & !busy
//  response  rsp_valid, rsp_payload              one-cycle strobe, no stall
//  csr       csr_valid, csr_ready, csr_index,    write on valid & ready
//            csr_data
//
//  A load produces no beat. A tick keeps busy high while the FILL_UP and
//  FILL_MID states prime the three-row window from the board memory's
//  registered read port, then through RUN and LAST at one row per cycle.
//  Each row's response beat is registered and appears in the next cycle.
//  Synchronous reset clears the board through per-row valid bits.
// ----------------------------------------------------------------------------
module life_generation_step
   import lgs_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_payload,

   output logic                     rsp_valid,
   output rsp_type                  rsp_payload,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int ROW_DEPTH = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int ROW_IDX_W = $clog2(ROW_DEPTH);
   localparam int ROW_CNT_W = $clog2(ROW_DEPTH+1);
   localparam int COL_CNT_W = $clog2(MAX_COLUMNS+1);

   // configuration
   logic [CSR_DATA_BITS-1:0] row_count_ff;
   logic [CSR_DATA_BITS-1:0] column_count_ff;
   logic                     wrap_ff;

   logic [ROW_CNT_W-1:0] rows_used;
   logic [COL_CNT_W-1:0] cols_used;
   logic [ROW_IDX_W-1:0] last_idx;

   // sequencer
   state_type state_ff, state_in;
   logic      accept, load_go, tick_go;
   logic      calc_en, use_row0;
   logic [ROW_IDX_W-1:0] rd_addr;
   logic [ROW_IDX_W-1:0] i_ff;

   // board memory
   logic [MAX_COLUMNS-1:0] mem [ROW_DEPTH];
   logic [ROW_DEPTH-1:0]   row_valid_ff, row_valid_in;
   logic [MAX_COLUMNS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [MAX_COLUMNS-1:0] rd_word;
   logic                   mem_we;
   logic [ROW_IDX_W-1:0]   mem_waddr;
   logic [MAX_COLUMNS-1:0] mem_wdata;

   // window
   logic [MAX_COLUMNS-1:0] up_ff, mid_ff, row0_ff;
   logic [MAX_COLUMNS-1:0] down_word, next_word;
   flags_type              flags;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
         wrap_ff         <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_data;
            CSR_COLUMN_COUNT: column_count_ff <= csr_data;
            CSR_WRAP_MODE:    wrap_ff         <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (row_count_ff == '0)
         rows_used = ROW_CNT_W'(1);
      else if (row_count_ff > CSR_DATA_BITS'(ROW_DEPTH))
         rows_used = ROW_CNT_W'(ROW_DEPTH);
      else
         rows_used = ROW_CNT_W'(row_count_ff);
   end

   always_comb begin
      priority if (column_count_ff == '0)
         cols_used = COL_CNT_W'(1);
      else if (column_count_ff > CSR_DATA_BITS'(MAX_COLUMNS))
         cols_used = COL_CNT_W'(MAX_COLUMNS);
      else
         cols_used = COL_CNT_W'(column_count_ff);
   end

   assign last_idx = ROW_IDX_W'(rows_used - ROW_CNT_W'(1));

   // ------------------------------------------------------------- sequencer
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign load_go = accept && (req_payload.operation == OP_LOAD);
   assign tick_go = accept && (req_payload.operation == OP_TICK);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (tick_go) state_in = ST_FILL_UP;
         ST_FILL_UP:  state_in = ST_FILL_MID;
         ST_FILL_MID: state_in = (last_idx == '0) ? ST_LAST : ST_RUN;
         ST_RUN:      if (i_ff + ROW_IDX_W'(1) == last_idx) state_in = ST_LAST;
         ST_LAST:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // read order: row R-1 (wrap source), row 0, row 1, ... one ahead of compute
   always_comb begin
      rd_addr  = '0;
      calc_en  = 1'b0;
      use_row0 = 1'b0;
      unique case (state_ff)
         ST_IDLE:     rd_addr = last_idx;
         ST_FILL_UP:  rd_addr = '0;
         ST_FILL_MID: rd_addr = ROW_IDX_W'(1);
         ST_RUN: begin
            rd_addr = i_ff + ROW_IDX_W'(2);
            calc_en = 1'b1;
         end
         ST_LAST: begin
            calc_en  = 1'b1;
            use_row0 = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------- board memory
   always_comb begin
      if (calc_en) begin
         mem_we    = 1'b1;
         mem_waddr = i_ff;
         mem_wdata = next_word;
      end else begin
         mem_we    = load_go && (7'(req_payload.row_index) < 7'(ROW_DEPTH));
         mem_waddr = ROW_IDX_W'(req_payload.row_index);
         mem_wdata = req_payload.row_cells[MAX_COLUMNS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // a tick drops every row past the area in use; written rows become valid
   always_comb begin
      row_valid_in = row_valid_ff;
      if (tick_go) begin
         for (int k = 0; k < ROW_DEPTH; k++) begin
            if (ROW_CNT_W'(k) >= rows_used) row_valid_in[k] = 1'b0;
         end
      end
      if (mem_we) row_valid_in[mem_waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[rd_addr];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

   // ---------------------------------------------------------------- window
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_FILL_UP: up_ff <= rd_word;
         ST_FILL_MID: begin
            mid_ff  <= rd_word;
            row0_ff <= rd_word;
            i_ff    <= '0;
         end
         ST_RUN: begin
            up_ff  <= mid_ff;
            mid_ff <= rd_word;
            i_ff   <= i_ff + ROW_IDX_W'(1);
         end
         default: ;
      endcase
   end

   assign down_word = use_row0 ? row0_ff : rd_word;

   assign flags.up_valid   = wrap_ff | (i_ff != '0);
   assign flags.down_valid = wrap_ff | (i_ff != last_idx);
   assign flags.row_self   = wrap_ff & (rows_used == ROW_CNT_W'(1));
   assign flags.col_self   = wrap_ff & (cols_used == COL_CNT_W'(1));

   lgs_row_unit #(
      .COLS (MAX_COLUMNS)
   ) u_row_unit (
      .up_word   (up_ff),
      .mid_word  (mid_ff),
      .down_word (down_word),
      .cols_used (cols_used),
      .wrap      (wrap_ff),
      .flags     (flags),
      .next_word (next_word)
   );

   // -------------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= calc_en;
      end
   end

   always_ff @(posedge clock) begin
      if (calc_en) begin
         rsp_ff.out_row_index <= ROW_IDX_BITS'(i_ff);
         rsp_ff.out_row_cells <= CELL_BITS'(next_word);
         rsp_ff.last_row      <= use_row0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
